### rtl/pcx_rle_pkg.sv
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// Shared constants and controller/datapath signal groups of the PCX
// run-length stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcx_rle_pkg;

  // fixed header length of the file, in bytes
  localparam int unsigned HEADER_BYTES = 128;
  // default upper bound of the pixel total
  localparam int unsigned MAX_PIXELS_DEF = 65536;
  // pixel total after reset
  localparam int unsigned TOTAL_RESET = 64000;

  // field widths
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned HDR_W   = 8;

  // bytes at or above this value open a run
  localparam logic [BYTE_W-1:0] RUN_MARK = 8'd192;

  // commands from controller to datapath
  typedef struct packed {
    logic hdr_dec;   // skip one header byte
    logic set_fin;   // image already complete, stop decoding
    logic take_run;  // byte is the value of a pending run
    logic take_lit;  // byte is a single literal pixel
    logic set_mark;  // byte is a run marker
    logic emit;      // load one pixel into the output register
  } pr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic finished;     // image done, bytes are dropped
    logic hdr_busy;     // header bytes still to skip
    logic past_end;     // pixel count has reached the total
    logic run_pending;  // a marker waits for its value byte
    logic mark;         // current input byte is a run marker
    logic run_zero;     // pending run has length zero
    logic slot_free;    // output register can take a pixel
    logic end_pixel;    // next pixel is the final one of the image
    logic last_remain;  // next pixel is the last of this byte
  } pr_sts_t;

endpackage

`default_nettype wire

### rtl/pcx_rle_ctrl.sv
// ----------------------------------------------------------------------------
// pcx_rle_ctrl
// Controller of the decoder: classifies each accepted byte and sequences
// pixel emission one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pcx_rle_pkg::pr_sts_t  sts,
  output pcx_rle_pkg::pr_cmd_t       cmd
);
  import pcx_rle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic in_acc;

  // bytes are taken only while no pixels are being sent
  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !sts.finished) begin
          if (sts.hdr_busy) begin
            cmd.hdr_dec = 1'b1;
          end else if (sts.past_end) begin
            cmd.set_fin = 1'b1;
          end else if (sts.run_pending) begin
            cmd.take_run = 1'b1;
            if (!sts.run_zero) begin
              state_nxt = ST_EMIT;
            end
          end else if (sts.mark) begin
            cmd.set_mark = 1'b1;
          end else begin
            cmd.take_lit = 1'b1;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_remain || sts.end_pixel) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pcx_rle_dp.sv
// ----------------------------------------------------------------------------
// pcx_rle_dp
// Datapath of the decoder: header and run state, pixel counter, pixel
// total register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_dp #(
  parameter int unsigned MAX_PIXELS = pcx_rle_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [pcx_rle_pkg::BYTE_W-1:0]      in_file_byte,
  input  wire logic                                cfg_we,
  input  wire logic [pcx_rle_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [pcx_rle_pkg::BYTE_W-1:0]           out_pixel_value,
  output logic [pcx_rle_pkg::IDX_W-1:0]            out_pixel_index,
  output logic                                     out_last_of_run,
  output logic                                     out_image_done,
  input  wire pcx_rle_pkg::pr_cmd_t                cmd,
  output pcx_rle_pkg::pr_sts_t                     sts
);
  import pcx_rle_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // decode state
  logic [HDR_W-1:0]  header_left_r, header_left_nxt;
  logic              run_pending_r, run_pending_nxt;
  logic [RUN_W-1:0]  run_count_r,   run_count_nxt;
  logic [CNT_W-1:0]  pw_r,          pw_nxt;
  logic              finished_r,    finished_nxt;
  logic [CNT_W-1:0]  total_r,       total_nxt;
  // current byte being expanded
  logic [BYTE_W-1:0] value_r,       value_nxt;
  logic [RUN_W-1:0]  remain_r,      remain_nxt;
  // output register
  logic              out_valid_r,   out_valid_nxt;
  logic [BYTE_W-1:0] out_value_r,   out_value_nxt;
  logic [IDX_W-1:0]  out_index_r,   out_index_nxt;
  logic              out_last_r,    out_last_nxt;
  logic              out_done_r,    out_done_nxt;

  logic [CNT_W-1:0]  pw_inc;
  logic [EXT_W-1:0]  pw_ext;
  logic [CMP_W-1:0]  cfg_ext;
  logic [CNT_W-1:0]  cfg_sat;
  logic              end_pixel;
  logic              last_remain;
  logic              slot_free;

  assign pw_inc      = pw_r + CNT_W'(1);
  assign pw_ext      = EXT_W'(pw_r);
  assign end_pixel   = (pw_inc == total_r);
  assign last_remain = (remain_r == RUN_W'(1));
  assign slot_free   = !out_valid_r || !out_stall;

  // status toward the controller
  assign sts.finished    = finished_r;
  assign sts.hdr_busy    = (header_left_r != '0);
  assign sts.past_end    = (pw_r >= total_r);
  assign sts.run_pending = run_pending_r;
  assign sts.mark        = (in_file_byte >= RUN_MARK);
  assign sts.run_zero    = (run_count_r == '0);
  assign sts.slot_free   = slot_free;
  assign sts.end_pixel   = end_pixel;
  assign sts.last_remain = last_remain;

  // pixel total saturated into one to the maximum
  always_comb begin
    cfg_ext = CMP_W'(cfg_wdata);
    if (cfg_ext == '0) begin
      cfg_sat = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_PIXELS)) begin
      cfg_sat = CNT_W'(MAX_PIXELS);
    end else begin
      cfg_sat = CNT_W'(cfg_ext);
    end
  end

  // next values
  always_comb begin
    header_left_nxt = header_left_r;
    run_pending_nxt = run_pending_r;
    run_count_nxt   = run_count_r;
    pw_nxt          = pw_r;
    finished_nxt    = finished_r;
    total_nxt       = total_r;
    value_nxt       = value_r;
    remain_nxt      = remain_r;
    out_value_nxt   = out_value_r;
    out_index_nxt   = out_index_r;
    out_last_nxt    = out_last_r;
    out_done_nxt    = out_done_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (cfg_we) begin
      total_nxt = cfg_sat;
    end
    if (cmd.hdr_dec) begin
      header_left_nxt = header_left_r - HDR_W'(1);
    end
    if (cmd.set_fin) begin
      finished_nxt = 1'b1;
    end
    if (cmd.set_mark) begin
      run_pending_nxt = 1'b1;
      run_count_nxt   = RUN_W'(in_file_byte - RUN_MARK);
    end
    if (cmd.take_run) begin
      run_pending_nxt = 1'b0;
      remain_nxt      = run_count_r;
      value_nxt       = in_file_byte;
    end
    if (cmd.take_lit) begin
      remain_nxt = RUN_W'(1);
      value_nxt  = in_file_byte;
    end
    // one pixel beat into the output register
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = value_r;
      out_index_nxt = pw_ext[IDX_W-1:0];
      out_last_nxt  = last_remain || end_pixel;
      out_done_nxt  = end_pixel;
      pw_nxt        = pw_inc;
      remain_nxt    = remain_r - RUN_W'(1);
      if (end_pixel) begin
        finished_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_left_r <= HDR_W'(HEADER_BYTES);
      run_pending_r <= 1'b0;
      run_count_r   <= '0;
      pw_r          <= '0;
      finished_r    <= 1'b0;
      total_r       <= CNT_W'(TOTAL_RESET);
      out_valid_r   <= 1'b0;
    end else begin
      header_left_r <= header_left_nxt;
      run_pending_r <= run_pending_nxt;
      run_count_r   <= run_count_nxt;
      pw_r          <= pw_nxt;
      finished_r    <= finished_nxt;
      total_r       <= total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    remain_r    <= remain_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_value_r;
  assign out_pixel_index = out_index_r;
  assign out_last_of_run = out_last_r;
  assign out_image_done  = out_done_r;

  // a pixel is loaded only into a free slot and never after the image ended
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (slot_free && !finished_r))
    else $error("pixel loaded into busy output or after image end");

  // the final pixel of the image stops decoding and is flagged
  a_final_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && end_pixel) |=> (finished_r && out_image_done && out_last_of_run))
    else $error("final pixel did not finish the image");

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.hdr_dec, cmd.set_fin, cmd.take_run, cmd.take_lit,
              cmd.set_mark, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

### rtl/pcx_rle_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// pcx_rle_stream_decoder_unit
// PCX run-length stream decoder: skips the file header and expands the
// run-length coded pixel data into one pixel beat per decoded pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one raw file byte per beat (in_valid / in_stall).
//   out_*  : one decoded pixel per beat with its index, a last-of-run mark
//            on the last pixel from a byte or of the image, an image-done
//            mark on the final pixel of the image (out_valid / out_stall).
//   cfg_*  : cfg_we writes the pixel total, saturated into 1..MAX_PIXELS;
//            write it only while idle.
//   Header bytes, marker bytes and bytes after the image are accepted with
//   no pixel out. A literal byte is accepted, then one pixel goes into the
//   output register. A run value byte of n pixels is accepted, then the
//   controller emits one pixel per cycle into the single output register
//   while it is free; in_stall stays high until the last pixel of the byte
//   or of the image is loaded. A stalled receiver pauses emission and holds
//   the output register. Reset resets the decode state, restores the pixel
//   total to 64000 and holds in_stall high while rst_n is low.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_stream_decoder_unit #(
  parameter int unsigned MAX_PIXELS = pcx_rle_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pcx_rle_pkg::BYTE_W-1:0]  in_file_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pcx_rle_pkg::BYTE_W-1:0]       out_pixel_value,
  output logic [pcx_rle_pkg::IDX_W-1:0]        out_pixel_index,
  output logic                                 out_last_of_run,
  output logic                                 out_image_done,
  input  wire logic                            cfg_we,
  input  wire logic [pcx_rle_pkg::CFG_W-1:0]   cfg_wdata
);
  import pcx_rle_pkg::*;

  pr_cmd_t cmd;
  pr_sts_t sts;

  // byte classification and pixel sequencing
  pcx_rle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // decode state, counters and output register
  pcx_rle_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_file_byte    (in_file_byte),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .out_pixel_index (out_pixel_index),
    .out_last_of_run (out_last_of_run),
    .out_image_done  (out_image_done),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
